[design/ncr_pkg.sv]
// ncr_pkg: types, character codes and utf-8 helpers for the numeric character
// reference decoder; no dependencies
package ncr_pkg;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_X_LC = 8'h78;
	localparam logic [7:0] CH_X_UC = 8'h58;

	localparam int unsigned CP_W = 21;
	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_REPLACE = 21'h00FFFD;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_AMP  = 3'd1,
		PH_HASH = 3'd2,
		PH_DEC  = 3'd3,
		PH_HEX  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOTREF = 2'd1,
		ST_NAMED  = 2'd2
	} status_t;

	typedef struct packed {
		status_t         status;
		logic [CP_W-1:0] cp;
	} cmd_t;

	// number of utf-8 bytes minus one
	function automatic logic [1:0] utf8_nm1(input logic [CP_W-1:0] cp);
		logic [1:0] n;
		if (cp < 21'h80) begin
			n = 2'd0;
		end else if (cp < 21'h800) begin
			n = 2'd1;
		end else if (cp < 21'h10000) begin
			n = 2'd2;
		end else begin
			n = 2'd3;
		end
		return n;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
		logic [7:0] b [4];
		b[0] = 8'h00;
		b[1] = 8'h00;
		b[2] = 8'h00;
		b[3] = 8'h00;
		case (utf8_nm1(cp))
			2'd0: begin
				b[0] = cp[7:0];
			end
			2'd1: begin
				b[0] = {3'b110, cp[10:6]};
				b[1] = {2'b10, cp[5:0]};
			end
			2'd2: begin
				b[0] = {4'b1110, cp[15:12]};
				b[1] = {2'b10, cp[11:6]};
				b[2] = {2'b10, cp[5:0]};
			end
			default: begin
				b[0] = {5'b11110, cp[20:18]};
				b[1] = {2'b10, cp[17:12]};
				b[2] = {2'b10, cp[11:6]};
				b[3] = {2'b10, cp[5:0]};
			end
		endcase
		return b[idx];
	endfunction

endpackage

[design/ncr_front.sv]
// ncr_front: byte parser, tracks the reference phase and accumulates the code point
// depends on ncr_pkg; pushes one command per finished candidate
module ncr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                q_full,
	output logic                in_ready,
	output logic                push,
	output ncr_pkg::cmd_t       push_cmd
);

	ncr_pkg::phase_t               phase_q, phase_d;
	logic [ncr_pkg::CP_W-1:0]      accum_q, accum_d;
	logic                          seen_q, seen_d;

	logic                          accept;
	logic                          is_dec, is_hex_letter, is_hex;
	logic [3:0]                    dig;
	logic [24:0]                   scaled, sum;
	logic                          over;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_dec        = in_byte inside {[8'h30:8'h39]};
		is_hex_letter = in_byte inside {[8'h41:8'h46], [8'h61:8'h66]};
		is_hex        = is_dec || is_hex_letter;
		dig           = is_hex_letter ? (in_byte[3:0] + 4'd9) : in_byte[3:0];
		if (phase_q == ncr_pkg::PH_HEX) begin
			scaled = {accum_q, 4'b0};
		end else begin
			scaled = {1'b0, accum_q, 3'b0} + {3'b0, accum_q, 1'b0};
		end
		sum  = scaled + {21'b0, dig};
		over = sum > {4'b0, ncr_pkg::CP_MAX};
	end

	always_comb begin
		phase_d         = phase_q;
		accum_d         = accum_q;
		seen_d          = seen_q;
		push            = 1'b0;
		push_cmd.status = ncr_pkg::ST_NOTREF;
		push_cmd.cp     = '0;
		if (accept) begin
			case (phase_q)
				ncr_pkg::PH_AMP: begin
					if (in_byte == ncr_pkg::CH_HASH) begin
						phase_d = ncr_pkg::PH_HASH;
					end else begin
						push            = 1'b1;
						push_cmd.status = ncr_pkg::ST_NAMED;
					end
				end
				ncr_pkg::PH_HASH: begin
					if (in_byte == ncr_pkg::CH_X_LC || in_byte == ncr_pkg::CH_X_UC) begin
						phase_d = ncr_pkg::PH_HEX;
					end else if (is_dec && !over) begin
						phase_d = ncr_pkg::PH_DEC;
						accum_d = sum[ncr_pkg::CP_W-1:0];
						seen_d  = 1'b1;
					end else begin
						push = 1'b1;
					end
				end
				ncr_pkg::PH_DEC, ncr_pkg::PH_HEX: begin
					if ((phase_q == ncr_pkg::PH_HEX) ? is_hex : is_dec) begin
						if (over) begin
							push = 1'b1;
						end else begin
							accum_d = sum[ncr_pkg::CP_W-1:0];
							seen_d  = 1'b1;
						end
					end else if (in_byte == ncr_pkg::CH_SEMI && seen_q) begin
						push            = 1'b1;
						push_cmd.status = ncr_pkg::ST_OK;
						push_cmd.cp     = (accum_q == '0) ? ncr_pkg::CP_REPLACE : accum_q;
					end else begin
						push = 1'b1;
					end
				end
				default: begin
					if (in_byte == ncr_pkg::CH_AMP) begin
						phase_d = ncr_pkg::PH_AMP;
						accum_d = '0;
						seen_d  = 1'b0;
					end else begin
						push = 1'b1;
					end
				end
			endcase
			if (push) begin
				phase_d = ncr_pkg::PH_IDLE;
				accum_d = '0;
				seen_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ncr_pkg::PH_IDLE;
			accum_q <= '0;
			seen_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			seen_q  <= seen_d;
		end
	end

endmodule

[design/ncr_fifo.sv]
// ncr_fifo: short command queue between parser and encoder
// depends on ncr_pkg; head entry is shown combinationally
module ncr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ncr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output ncr_pkg::cmd_t head_cmd
);

	localparam int unsigned CW = ncr_pkg::FIFO_AW + 1;

	ncr_pkg::cmd_t               mem_q [ncr_pkg::FIFO_DEPTH];
	logic [ncr_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [CW-1:0]               count_q;
	logic                        do_push, do_pop;

	assign full       = count_q == CW'(ncr_pkg::FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/ncr_back.sv]
// ncr_back: turns queued commands into utf-8 bytes or single status results
// depends on ncr_pkg; holds the output register of the result stream
module ncr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  ncr_pkg::cmd_t    head_cmd,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output ncr_pkg::status_t out_status,
	output logic             out_last
);

	logic [1:0]       idx_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	ncr_pkg::status_t status_q;
	logic             last_q;

	logic             load, last;
	logic [1:0]       nm1;
	logic [7:0]       byte_d;

	always_comb begin
		if (head_cmd.status == ncr_pkg::ST_OK) begin
			nm1    = ncr_pkg::utf8_nm1(head_cmd.cp);
			byte_d = ncr_pkg::utf8_byte(head_cmd.cp, idx_q);
		end else begin
			nm1    = 2'd0;
			byte_d = 8'h00;
		end
		last = idx_q == nm1;
		load = head_valid && (!valid_q || out_ready);
		pop  = load && last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_d;
			status_q <= head_cmd.status;
			last_q   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign out_status = status_q;
	assign out_last   = last_q;

endmodule

[design/numeric_char_reference_decoder.sv]
// numeric_char_reference_decoder: top level, decodes &#...; references to utf-8
// depends on ncr_pkg, ncr_front, ncr_fifo, ncr_back
//
//   channel  | direction | tdata          | tuser       | tlast
//   s_axis   | in        | [7:0] in_byte  | -           | -
//   m_axis   | out       | [7:0] out_byte | [1:0] status| last_byte
//
// one input byte per cycle while the queue has room; each result item leaves
// one per cycle from the output register while m_axis_tready is high, after
// the command queue; a decoded character is one to four bytes, set by the
// encoder; a four-entry command queue lets the parser run ahead of the encoder
// s_axis_tready drops only while that queue is full; reset clears all control
module numeric_char_reference_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [1:0] status
	output logic       m_axis_tlast
);

	logic             q_full, push, pop, head_valid;
	ncr_pkg::cmd_t    push_cmd, head_cmd;
	ncr_pkg::status_t out_status;

	ncr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.in_ready (s_axis_tready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ncr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	ncr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.out_status (out_status),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tuser = out_status;

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ncr_pkg::ST_OK) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
		else $error("status result not a single zero item");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ncr_pkg::ST_OK || m_axis_tuser == ncr_pkg::ST_NOTREF ||
			m_axis_tuser == ncr_pkg::ST_NAMED))
		else $error("illegal status code");

	a_cont_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
			(!m_axis_tvalid || m_axis_tdata[7:6] == 2'b10))
		else $error("utf-8 sequence broken after a leading byte");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command pushed into a full queue");

endmodule
